@@ design/srl_pkg.sv @@
// ----------------------------------------------------------------------------
// srl_pkg: shared types and constants of the sequential record list
// Field widths, request and status codes, cell commands and scan status.
// ----------------------------------------------------------------------------
`default_nettype none

package srl_pkg;

   localparam int DEPTH_DEFAULT = 128;

   localparam int MODE_W   = 2;
   localparam int POS_W    = 8;
   localparam int ID_W     = 16;
   localparam int SCORE_W  = 14;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 7;
   localparam int COUNT_W  = 8;

   // lanes examined per scan cycle, and the lane number width
   localparam int SCAN_LANES = 8;
   localparam int LANE_W     = 3;

   typedef enum logic [MODE_W-1:0] {
      MODE_APPEND,
      MODE_INSERT,
      MODE_DELETE,
      MODE_SEARCH
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_BAD_POS,
      STATUS_FULL,
      STATUS_MISSING
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_SHIFT_UP,
      CELL_SHIFT_DOWN
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_APPLY
   } srl_state_type;

   typedef struct packed {
      cell_op_type            op;
      logic [ID_W-1:0]        key;
      logic [SCORE_W-1:0]     score;
   } cell_cmd_type;

   typedef struct packed {
      logic                   hit;
      logic [LANE_W-1:0]      lane;
      logic [SCORE_W-1:0]     score;
   } scan_status_type;

endpackage

`default_nettype wire

@@ design/srl_cell.sv @@
// ----------------------------------------------------------------------------
// srl_cell: one record slot of the list
// Holds one (id, score) record, takes a neighbor's record on a shift and
// flags a key match when the slot lies below the record count.
// ----------------------------------------------------------------------------
`default_nettype none

module srl_cell #(
   parameter int INDEX = 0,
   parameter int IW    = 7,
   parameter int CW    = 8
) (
   input  logic                          clock,
   input  srl_pkg::cell_cmd_type         cmd,
   input  logic [IW-1:0]                 pivot,
   input  logic [CW-1:0]                 count,
   input  logic [srl_pkg::ID_W-1:0]      prev_id,
   input  logic [srl_pkg::SCORE_W-1:0]   prev_score,
   input  logic [srl_pkg::ID_W-1:0]      next_id,
   input  logic [srl_pkg::SCORE_W-1:0]   next_score,
   output logic [srl_pkg::ID_W-1:0]      id,
   output logic [srl_pkg::SCORE_W-1:0]   score,
   output logic                          match
);
   import srl_pkg::*;

   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
   localparam logic [CW-1:0] MY_POS = CW'(INDEX);

   logic [ID_W-1:0]    id_ff, id_in;
   logic [SCORE_W-1:0] score_ff, score_in;

   always_comb begin
      id_in    = id_ff;
      score_in = score_ff;
      case (cmd.op)
         CELL_WRITE: begin
            if (MY_IDX == pivot) begin
               id_in    = cmd.key;
               score_in = cmd.score;
            end
         end
         CELL_SHIFT_UP: begin
            // open a gap at the pivot, move later records up one slot
            if (MY_IDX > pivot) begin
               id_in    = prev_id;
               score_in = prev_score;
            end else if (MY_IDX == pivot) begin
               id_in    = cmd.key;
               score_in = cmd.score;
            end
         end
         CELL_SHIFT_DOWN: begin
            // close the gap left by the removed record
            if (MY_IDX >= pivot) begin
               id_in    = next_id;
               score_in = next_score;
            end
         end
         default: begin
            id_in    = id_ff;
            score_in = score_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      score_ff <= score_in;
   end

   assign id    = id_ff;
   assign score = score_ff;
   assign match = (id_ff == cmd.key) && (MY_POS < count);

endmodule

`default_nettype wire

@@ design/srl_scan.sv @@
// ----------------------------------------------------------------------------
// srl_scan: first-match search over the cell match flags
// Captures all match flags and scores, then walks them a group of lanes
// per advance cycle; reports the lowest matching lane of the current group.
// ----------------------------------------------------------------------------
`default_nettype none

module srl_scan #(
   parameter int DEPTH = srl_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic                          advance,
   input  logic [DEPTH-1:0]              match_vec,
   input  logic [srl_pkg::SCORE_W-1:0]   score_vec [DEPTH],
   output srl_pkg::scan_status_type      status
);
   import srl_pkg::*;

   localparam int NG   = (DEPTH + SCAN_LANES - 1) / SCAN_LANES;
   localparam int PADW = NG * SCAN_LANES;
   localparam int PW   = $clog2(PADW);

   logic [PADW-1:0]    pad_match;
   logic [SCORE_W-1:0] pad_score [PADW];
   logic [PADW-1:0]    match_ff, match_in;
   logic [SCORE_W-1:0] score_ff [PADW];
   logic [SCORE_W-1:0] score_in [PADW];

   for (genvar k = 0; k < PADW; k++) begin : g_lane
      if (k < DEPTH) begin : g_real
         assign pad_match[k] = match_vec[k];
         assign pad_score[k] = score_vec[k];
      end else begin : g_pad
         assign pad_match[k] = 1'b0;
         assign pad_score[k] = '0;
      end
      if (k + SCAN_LANES < PADW) begin : g_mid
         assign score_in[k] = load ? pad_score[k] :
                              advance ? score_ff[k + SCAN_LANES] : score_ff[k];
      end else begin : g_top
         assign score_in[k] = load ? pad_score[k] : score_ff[k];
      end
   end

   assign match_in = load ? pad_match :
                     advance ? (match_ff >> SCAN_LANES) : match_ff;

   always_ff @(posedge clock) begin
      match_ff <= match_in;
      score_ff <= score_in;
   end

   // lowest set lane of the bottom group wins
   always_comb begin
      status.hit  = |match_ff[SCAN_LANES-1:0];
      status.lane = '0;
      for (int k = SCAN_LANES - 1; k >= 0; k--) begin
         if (match_ff[k]) begin
            status.lane = LANE_W'(k);
         end
      end
      status.score = score_ff[PW'(status.lane)];
   end

endmodule

`default_nettype wire

@@ design/sequential_record_list_core.sv @@
// ----------------------------------------------------------------------------
// sequential_record_list_core: ordered list of (id, score) records
// Append, insert at position, delete by id and search by id on a row of
// record cells, with a lane-group scan for the first match.
// ----------------------------------------------------------------------------
//
//   channel   ports                                  handshake
//   request   req_mode req_position req_student_id   start high, busy low
//             req_score_hundredths
//   result    rsp_status rsp_found_index             rsp_valid, one cycle,
//             rsp_found_score rsp_record_count       cannot be held off
//
// Append and insert go straight to the apply state; delete and search
// pass through load, scan and apply, the scan walking the 8-lane groups
// up to and including the group of the first match, or all on a miss.
// The result strobe comes in the first cycle with busy low; a new
// transaction may be started in that same cycle.
// Reset clears the state machine, the record count and the strobe; record
// contents are left as they are and are only read below the count.
// ----------------------------------------------------------------------------
`default_nettype none

module sequential_record_list_core #(
   parameter int DEPTH = srl_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [srl_pkg::MODE_W-1:0]    req_mode,
   input  logic [srl_pkg::POS_W-1:0]     req_position,
   input  logic [srl_pkg::ID_W-1:0]      req_student_id,
   input  logic [srl_pkg::SCORE_W-1:0]   req_score_hundredths,
   output logic                          rsp_valid,
   output logic [srl_pkg::STATUS_W-1:0]  rsp_status,
   output logic [srl_pkg::INDEX_W-1:0]   rsp_found_index,
   output logic [srl_pkg::SCORE_W-1:0]   rsp_found_score,
   output logic [srl_pkg::COUNT_W-1:0]   rsp_record_count
);
   import srl_pkg::*;

   localparam int IW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int NG   = (DEPTH + SCAN_LANES - 1) / SCAN_LANES;
   localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
   localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

   localparam logic [GW-1:0] LAST_GROUP = GW'(NG - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   // control state
   srl_state_type      state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // request hold and scan results
   mode_type           mode_ff, mode_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [ID_W-1:0]    key_ff, key_in;
   logic [SCORE_W-1:0] score_ff, score_in;
   logic [GW-1:0]      grp_ff, grp_in;
   logic               found_ff, found_in;
   logic [IW-1:0]      hit_ff, hit_in;
   logic [SCORE_W-1:0] hit_score_ff, hit_score_in;

   // result registers
   status_type         status_ff, status_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [SCORE_W-1:0] fscore_ff, fscore_in;
   logic [COUNT_W-1:0] rcount_ff, rcount_in;

   // cell row and scan wiring
   cell_cmd_type       cmd;
   logic [IW-1:0]      pivot;
   logic [ID_W-1:0]    cell_id [DEPTH];
   logic [SCORE_W-1:0] cell_score [DEPTH];
   logic [DEPTH-1:0]   cell_match;
   logic               scan_load;
   logic               scan_advance;
   scan_status_type    scan_st;

   logic                  accept;
   logic [GW+LANE_W-1:0]  hit_full;
   logic [CMPW-1:0]       pos_x;
   logic [CMPW-1:0]       cnt_x;
   logic [CMPW-1:0]       pos_m1;
   logic                  list_full;
   logic [IW+INDEX_W-1:0] index_ext;
   logic [CW+COUNT_W-1:0] count_ext;

   assign accept   = start && (state_ff == ST_IDLE);
   assign hit_full = {grp_ff, scan_st.lane};
   assign pos_x    = CMPW'(pos_ff);
   assign cnt_x    = CMPW'(count_ff);
   assign pos_m1   = pos_x - CMPW'(1);
   assign list_full = (count_ff == FULL_COUNT);

   // ------------------------------------------------------------------
   // record cells: each slot talks only to its two neighbors
   // ------------------------------------------------------------------
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ID_W-1:0]    p_id, n_id;
      logic [SCORE_W-1:0] p_score, n_score;

      if (i == 0) begin : g_first
         assign p_id    = cell_id[i];
         assign p_score = cell_score[i];
      end else begin : g_prev
         assign p_id    = cell_id[i-1];
         assign p_score = cell_score[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign n_id    = cell_id[i];
         assign n_score = cell_score[i];
      end else begin : g_next
         assign n_id    = cell_id[i+1];
         assign n_score = cell_score[i+1];
      end

      srl_cell #(
         .INDEX (i),
         .IW    (IW),
         .CW    (CW)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .pivot      (pivot),
         .count      (count_ff),
         .prev_id    (p_id),
         .prev_score (p_score),
         .next_id    (n_id),
         .next_score (n_score),
         .id         (cell_id[i]),
         .score      (cell_score[i]),
         .match      (cell_match[i])
      );
   end

   srl_scan #(
      .DEPTH (DEPTH)
   ) u_scan (
      .clock     (clock),
      .load      (scan_load),
      .advance   (scan_advance),
      .match_vec (cell_match),
      .score_vec (cell_score),
      .status    (scan_st)
   );

   // ------------------------------------------------------------------
   // sequencer: next state, cell commands and result
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      mode_in      = mode_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      score_in     = score_ff;
      grp_in       = grp_ff;
      found_in     = found_ff;
      hit_in       = hit_ff;
      hit_score_in = hit_score_ff;
      status_in    = status_ff;
      index_in     = index_ff;
      fscore_in    = fscore_ff;
      rcount_in    = rcount_ff;
      scan_load    = 1'b0;
      scan_advance = 1'b0;
      cmd.op       = CELL_HOLD;
      cmd.key      = key_ff;
      cmd.score    = score_ff;
      pivot        = '0;
      index_ext    = '0;
      count_ext    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // hold the request for the whole transaction
               mode_in  = mode_type'(req_mode);
               pos_in   = req_position;
               key_in   = req_student_id;
               score_in = req_score_hundredths;
               if ((mode_type'(req_mode) == MODE_APPEND) ||
                   (mode_type'(req_mode) == MODE_INSERT)) begin
                  state_in = ST_APPLY;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            // snapshot every cell's match flag and score
            scan_load = 1'b1;
            grp_in    = '0;
            found_in  = 1'b0;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_st.hit) begin
               found_in     = 1'b1;
               hit_in       = hit_full[IW-1:0];
               hit_score_in = scan_st.score;
               state_in     = ST_APPLY;
            end else if (grp_ff == LAST_GROUP) begin
               state_in = ST_APPLY;
            end else begin
               scan_advance = 1'b1;
               grp_in       = grp_ff + GW'(1);
            end
         end
         ST_APPLY: begin
            rsp_valid_in = 1'b1;
            status_in    = STATUS_OK;
            fscore_in    = '0;
            index_ext    = '0;
            case (mode_ff)
               MODE_APPEND: begin
                  if (list_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     cmd.op   = CELL_WRITE;
                     pivot    = count_ff[IW-1:0];
                     count_in = count_ff + CW'(1);
                  end
               end
               MODE_INSERT: begin
                  // position range check comes before the full check
                  if ((pos_x == '0) || (pos_x > (cnt_x + CMPW'(1)))) begin
                     status_in = STATUS_BAD_POS;
                  end else if (list_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     cmd.op   = CELL_SHIFT_UP;
                     pivot    = pos_m1[IW-1:0];
                     count_in = count_ff + CW'(1);
                  end
               end
               MODE_DELETE: begin
                  if (found_ff) begin
                     cmd.op    = CELL_SHIFT_DOWN;
                     pivot     = hit_ff;
                     count_in  = count_ff - CW'(1);
                     index_ext = {INDEX_W'(0), hit_ff};
                  end else begin
                     status_in = STATUS_MISSING;
                  end
               end
               MODE_SEARCH: begin
                  if (found_ff) begin
                     index_ext = {INDEX_W'(0), hit_ff};
                     fscore_in = hit_score_ff;
                  end else begin
                     status_in = STATUS_MISSING;
                  end
               end
               default: begin
                  status_in = STATUS_OK;
               end
            endcase
            index_in  = index_ext[INDEX_W-1:0];
            count_ext = {COUNT_W'(0), count_in};
            rcount_in = count_ext[COUNT_W-1:0];
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      pos_ff       <= pos_in;
      key_ff       <= key_in;
      score_ff     <= score_in;
      grp_ff       <= grp_in;
      found_ff     <= found_in;
      hit_ff       <= hit_in;
      hit_score_ff <= hit_score_in;
      status_ff    <= status_in;
      index_ff     <= index_in;
      fscore_ff    <= fscore_in;
      rcount_ff    <= rcount_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_found_index  = index_ff;
   assign rsp_found_score  = fscore_ff;
   assign rsp_record_count = rcount_ff;

endmodule

`default_nettype wire

@@ design/srl_checker.sv @@
// ----------------------------------------------------------------------------
// srl_checker: port-level checks of the record list
// Watches the command handshake and the result strobe over time.
// ----------------------------------------------------------------------------
`default_nettype none

module srl_port_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // an accepted transaction makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted transaction");

   // busy only rises from an accepted transaction
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> ($past(start) && !$past(reset)))
      else $error("busy rose without a transaction");

   // a result ends a busy period and shows while idle
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result strobe outside the end of a transaction");

   // one result per transaction
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

endmodule

bind sequential_record_list_core srl_port_checker u_srl_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

`default_nettype wire
